// File: sv/smig_pkg.sv
package smig_pkg;

    localparam int IDX_W  = 15;
    localparam int CNT_W  = 8;
    localparam int RING_W = CNT_W + 1;

    localparam int MIN_EDGES   = 2;
    localparam int MAX_EDGES   = 128;
    localparam int EDGES_RESET = 8;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [RING_W-1:0] t_ring;

    typedef struct packed {
        logic       added_vertex;
        t_idx       vertex_number;
        t_cnt       theta_step;
        t_cnt       phi_step;
        logic [1:0] tri_count;
        t_idx       first_a;
        t_idx       first_b;
        t_idx       first_c;
        t_idx       second_a;
        t_idx       second_b;
        t_idx       second_c;
        logic       mesh_done;
    } t_result;

endpackage

// File: sv/smig_if.sv
interface smig_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface smig_out_if;
    logic              valid;
    logic              ready;
    smig_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/sphere_mesh_index_generator.sv
// A result goes into the result register, or into the skid while the output stalls.
// Throughput: one grid point per cycle while the skid is empty; the walk state is
// computed combinationally from the position counters, so a beat can be taken on
// every clock until the skid fills. A two-entry output buffer (result register plus
// skid) takes one beat during an output stall, then input ready drops until it drains.
// Reset (synchronous, active low): walk restarts at the north pole, n = 8, buffers empty.
module sphere_mesh_index_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    smig_in_if.sink            i_in,
    smig_out_if.source         o_out
);
    import smig_pkg::*;

    // configuration and walk state
    t_cnt    r_edges;
    t_cnt    r_lat, n_lat;
    t_cnt    r_lon, n_lon;
    t_idx    r_vtx, n_vtx;
    logic    r_fin, n_fin;

    // output buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    // working values
    t_cnt    lat, lon, n_used;
    t_idx    vtx, last, over, back, overback, ring_x, lon_x;
    logic    fin_now, add;
    t_ring   ring, lon_inc;
    t_result res;
    logic    in_fire, out_free;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = !r_skid_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // compute the result for the current grid point and the next position
    always_comb begin
        lat = i_in.restart ? '0 : r_lat;
        lon = i_in.restart ? '0 : r_lon;
        vtx = i_in.restart ? '0 : r_vtx;

        if (r_edges < CNT_W'(MIN_EDGES)) begin
            n_used = CNT_W'(MIN_EDGES);
        end else if (r_edges > CNT_W'(MAX_EDGES)) begin
            n_used = CNT_W'(MAX_EDGES);
        end else begin
            n_used = r_edges;
        end
        ring    = {n_used, 1'b0};
        ring_x  = IDX_W'(ring);
        lon_x   = IDX_W'(lon);
        lon_inc = RING_W'(lon) + RING_W'(1);

        fin_now = (!i_in.restart && r_fin) || (lat > n_used) || (RING_W'(lon) >= ring);

        add      = !(lat == n_used && lon != '0);
        last     = add ? vtx : vtx - IDX_W'(1);
        over     = add ? last - ring_x : last - ring_x + lon_x;
        back     = (lon != '0) ? last - IDX_W'(1) : last + ring_x - IDX_W'(1);
        overback = (lon != '0) ? over - IDX_W'(1) : over + ring_x - IDX_W'(1);

        res               = '0;
        res.added_vertex  = add;
        res.vertex_number = last;
        res.theta_step    = lat;
        res.phi_step      = lon;
        if (lat == CNT_W'(1)) begin
            res.tri_count = 2'd1;
            res.first_a   = back;
            res.first_b   = last;
        end else if (lat == n_used) begin
            res.tri_count = 2'd1;
            res.first_a   = overback;
            res.first_b   = last;
            res.first_c   = over;
        end else if (lat != '0) begin
            res.tri_count = 2'd2;
            res.first_a   = back;
            res.first_b   = last;
            res.first_c   = over;
            res.second_a  = back;
            res.second_b  = over;
            res.second_c  = overback;
        end

        n_lat = lat;
        n_lon = lon;
        n_vtx = vtx;
        n_fin = fin_now;
        if (fin_now) begin
            res           = '0;
            res.mesh_done = 1'b1;
        end else begin
            n_vtx = add ? vtx + IDX_W'(1) : vtx;
            if (lat == '0) begin
                n_lat = CNT_W'(1);
                n_lon = '0;
            end else if (lon_inc < ring) begin
                n_lon = lon_inc[CNT_W-1:0];
            end else begin
                n_lon = '0;
                if (lat == n_used) begin
                    n_fin         = 1'b1;
                    res.mesh_done = 1'b1;
                end else begin
                    n_lat = lat + CNT_W'(1);
                end
            end
        end
    end

    // hold configuration and walk state; advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges <= CNT_W'(EDGES_RESET);
            r_lat   <= '0;
            r_lon   <= '0;
            r_vtx   <= '0;
            r_fin   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_edges <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_lat <= n_lat;
                r_lon <= n_lon;
                r_vtx <= n_vtx;
                r_fin <= n_fin;
            end
        end
    end

    // result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

endmodule

// File: sv/smig_checker.sv
module smig_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input smig_pkg::t_result i_out_data
);
    import smig_pkg::*;

    // input stalls only after the output stalled
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_out_valid && !i_out_ready))
        else $error("input ready dropped without output stall");

    // every accepted beat is followed by output valid in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted beat produced no result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

    // at most two triangles
    a_tri_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.tri_count != 2'd3))
        else $error("triangle count out of range");

    // a point without a new vertex is a south-ring point past longitude zero
    a_south_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.added_vertex && !i_out_data.mesh_done)
            |-> (i_out_data.phi_step != '0 && i_out_data.tri_count == 2'd1))
        else $error("shared vertex outside south ring");

endmodule

bind sphere_mesh_index_generator smig_checker u_smig_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// File: tb/smig_point_checker.sv
`timescale 1ns / 100ps

module smig_point_checker
    import smig_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    smig_in_if         in_mon,
    smig_out_if        out_mon,
    output int         o_pending,
    output int         o_fail_count
);

    // Own copy of the size register and of the walk position
    t_cnt    edges_reg;
    t_cnt    cur_lat;
    t_cnt    cur_lon;
    t_idx    next_vert;
    logic    walk_done;
    int      fails;
    t_result expected_points[$];

    // Compute the result of one grid tick and advance the walk
    function automatic t_result walk_point(input logic restart);
        t_result     r;
        int unsigned n;
        int unsigned ring;
        logic        add;
        t_idx        ring_idx;
        t_idx        last;
        t_idx        over;
        t_idx        back;
        t_idx        overback;

        r = '0;
        if (restart) begin
            cur_lat   = '0;
            cur_lon   = '0;
            next_vert = '0;
            walk_done = 1'b0;
        end

        // Clamp the size into the supported range
        n = edges_reg;
        if (n < MIN_EDGES) n = MIN_EDGES;
        if (n > MAX_EDGES) n = MAX_EDGES;
        ring = 2 * n;

        // Stop at once when the position falls outside the grid
        if (cur_lat > n || cur_lon >= ring) walk_done = 1'b1;
        if (walk_done) begin
            r.mesh_done = 1'b1;
            return r;
        end

        // South ring reuses the pole vertex after longitude 0
        ring_idx = t_idx'(ring);
        add      = !(cur_lat == n && cur_lon != 0);
        last     = add ? next_vert : next_vert - 1'b1;
        over     = add ? last - ring_idx : last - ring_idx + t_idx'(cur_lon);
        back     = (cur_lon != 0) ? last - 1'b1 : last + ring_idx - 1'b1;
        overback = (cur_lon != 0) ? over - 1'b1 : over + ring_idx - 1'b1;

        // One triangle next to a pole, two on inner rings
        if (cur_lat == 1) begin
            r.first_a   = back;
            r.first_b   = last;
            r.first_c   = '0;
            r.tri_count = 2'd1;
        end else if (cur_lat == n) begin
            r.first_a   = overback;
            r.first_b   = last;
            r.first_c   = over;
            r.tri_count = 2'd1;
        end else if (cur_lat != 0) begin
            r.first_a   = back;
            r.first_b   = last;
            r.first_c   = over;
            r.second_a  = back;
            r.second_b  = over;
            r.second_c  = overback;
            r.tri_count = 2'd2;
        end

        r.added_vertex  = add;
        r.vertex_number = last;
        r.theta_step    = cur_lat;
        r.phi_step      = cur_lon;

        if (add) next_vert = next_vert + 1'b1;

        // Advance to the next grid point
        if (cur_lat == 0) begin
            cur_lat = 8'd1;
            cur_lon = '0;
        end else if (int'(cur_lon) + 1 < int'(ring)) begin
            cur_lon = cur_lon + 1'b1;
        end else begin
            cur_lon = '0;
            if (cur_lat == n) begin
                walk_done   = 1'b1;
                r.mesh_done = 1'b1;
            end else begin
                cur_lat = cur_lat + 1'b1;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    // Compare result beats, predict the result of each input beat, track register writes
    always @(posedge i_clk) begin
        t_result want;
        t_result got;

        if (!i_rst_n) begin
            edges_reg = t_cnt'(EDGES_RESET);
            cur_lat   = '0;
            cur_lon   = '0;
            next_vert = '0;
            walk_done = 1'b0;
            fails     = 0;
            expected_points.delete();
        end else begin
            if (out_mon.valid && out_mon.ready) begin
                got = out_mon.data;
                if (expected_points.size() == 0) begin
                    $error("result beat with no grid point pending");
                    fails++;
                end else begin
                    want = expected_points.pop_front();
                    check_field("added_vertex", want.added_vertex, got.added_vertex);
                    check_field("vertex_number", want.vertex_number, got.vertex_number);
                    check_field("theta_step", want.theta_step, got.theta_step);
                    check_field("phi_step", want.phi_step, got.phi_step);
                    check_field("tri_count", want.tri_count, got.tri_count);
                    check_field("first_a", want.first_a, got.first_a);
                    check_field("first_b", want.first_b, got.first_b);
                    check_field("first_c", want.first_c, got.first_c);
                    check_field("second_a", want.second_a, got.second_a);
                    check_field("second_b", want.second_b, got.second_b);
                    check_field("second_c", want.second_c, got.second_c);
                    check_field("mesh_done", want.mesh_done, got.mesh_done);
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                expected_points.push_back(walk_point(in_mon.restart));
            end
            if (i_cfg_we) edges_reg = i_cfg_wdata;
        end
        o_pending    <= expected_points.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import smig_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_TICKS = 750;
    localparam int QUIET_FROM   = 620;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic       quiet;
    int         pending;
    int         fail_count;
    int         cycle_count;

    smig_in_if  in_ch ();
    smig_out_if out_ch ();

    sphere_mesh_index_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    smig_point_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // End the run if it hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stall the result side in random bursts
    initial begin : result_ready_ctl
        int burst;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                burst = $urandom_range(1, 15);
                out_ch.ready <= 1'b0;
            end else begin
                burst = $urandom_range(1, 30);
                out_ch.ready <= 1'b1;
            end
            repeat (burst) @(posedge i_clk);
        end
    end

    // Send one grid tick, with an optional gap ahead of it
    task automatic send_tick(input logic restart);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Hold input until every pending result has drained
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_edges(input logic [7:0] value);
        wait_drained();
        repeat (3) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        int unsigned n;
        int unsigned walk_len;
        logic [7:0]  value;
        logic        first_restart;

        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.restart = 1'b0;
        quiet         = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Start from reset at the default size
        send_tick(1'b0);
        send_tick(1'b0);

        // Full walk of the smallest grid and two idle ticks past it
        write_edges(8'd2);
        send_tick(1'b1);
        repeat (10) send_tick(1'b0);

        // Oversized register clamps to the largest grid
        write_edges(8'd255);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);

        // Shrink the grid under the current longitude: walk ends at once
        write_edges(8'd3);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        write_edges(8'd2);
        send_tick(1'b0);

        // Zero clamps to the smallest grid
        write_edges(8'd0);
        send_tick(1'b1);
        send_tick(1'b0);

        // Random phases: mostly small grids walked from the pole
        sent = 0;
        while (sent < RANDOM_TICKS) begin
            pick  = $urandom_range(0, 19);
            if (pick < 14)       value = 8'($urandom_range(0, 5));
            else if (pick < 17)  value = 8'($urandom_range(6, 16));
            else if (pick == 17) value = 8'(MAX_EDGES);
            else if (pick == 18) value = 8'($urandom_range(MAX_EDGES + 1, 255));
            else                 value = 8'($urandom_range(0, 255));
            write_edges(value);

            n = value;
            if (n < MIN_EDGES) n = MIN_EDGES;
            if (n > MAX_EDGES) n = MAX_EDGES;
            walk_len = 1 + 2 * n * n;
            if (n > 16) len = $urandom_range(20, 80);
            else        len = $urandom_range(4, (walk_len + 4 > 120) ? 120 : walk_len + 4);
            if (len > RANDOM_TICKS - sent) len = RANDOM_TICKS - sent;

            first_restart = ($urandom_range(0, 3) != 0);
            for (int unsigned i = 0; i < len; i++) begin
                quiet = (sent >= QUIET_FROM);
                if (i == 0) send_tick(first_restart);
                else        send_tick($urandom_range(0, 47) == 0);
                sent++;
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/smig_pkg.sv
sv/smig_if.sv
sv/sphere_mesh_index_generator.sv
sv/smig_checker.sv
tb/smig_point_checker.sv
tb/tb_top.sv
